[rtl/core/speed_step_momentum_ramp_defines.svh]
// Assertion macros used by the checker of the speed step momentum ramp.
// Depends on nothing; include by bare file name.
`ifndef SPEED_STEP_MOMENTUM_RAMP_DEFINES_SVH
`define SPEED_STEP_MOMENTUM_RAMP_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define SSMR_ASSERT_HOLDS(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("ssmr check failed");

// Condition implies consequence in the following cycle.
`define SSMR_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("ssmr check failed");

`endif

[rtl/core/ssmr_pkg.sv]
// Types and constants of the speed step momentum ramp.
// Used by the serial divider, the top level and the checker; depends on nothing.
package ssmr_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } ramp_state_type;

   localparam logic [1:0] REG_ACCEL_RATE  = 2'd0;
   localparam logic [1:0] REG_DECEL_RATE  = 2'd1;
   localparam logic [1:0] REG_KICK_ENABLE = 2'd2;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_ESTOP  = 1'b1;

   localparam int ACCUM_WIDTH   = 32;
   localparam int RATE_WIDTH    = 24;
   localparam int ELAPSED_WIDTH = 16;
   localparam int STEP_WIDTH    = 8;

   localparam logic signed [7:0] SPEED_FWD_STOP = 8'sd1;
   localparam logic signed [7:0] SPEED_REV_STOP = -8'sd1;
   localparam logic signed [7:0] SPEED_NEG_MAX  = -8'sd127;
   localparam logic signed [7:0] SPEED_BAD_MIN  = -8'sd128;

   typedef struct packed {
      logic                  done;
      logic [STEP_WIDTH-1:0] steps;
   } div_result_type;

endpackage

[rtl/core/ssmr_divider.sv]
// Bit-serial restoring divider: accumulated time over the ramp rate, one quotient
// bit per cycle, quotient saturated to 8 bits. Depends on ssmr_pkg.
module ssmr_divider
   import ssmr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [ACCUM_WIDTH-1:0] dividend,
   input  logic [RATE_WIDTH-1:0]  divisor,
   output div_result_type         result
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [4:0]             count_ff, count_in;
   logic [ACCUM_WIDTH-1:0] dividend_ff, dividend_in;
   logic [RATE_WIDTH-1:0]  divisor_ff, divisor_in;
   logic [RATE_WIDTH-1:0]  remainder_ff, remainder_in;
   logic [STEP_WIDTH-1:0]  quotient_ff, quotient_in;
   logic                   overflow_ff, overflow_in;

   logic [RATE_WIDTH:0]    shifted;
   logic [RATE_WIDTH:0]    trial;
   logic                   fits;

   // The dividend leaves MSB first; the remainder never exceeds the divisor width.
   assign shifted = {remainder_ff, dividend_ff[ACCUM_WIDTH-1]};
   assign fits    = shifted >= {1'b0, divisor_ff};
   assign trial   = shifted - {1'b0, divisor_ff};

   always_comb begin
      busy_in      = busy_ff;
      done_in      = 1'b0;
      count_in     = count_ff;
      dividend_in  = dividend_ff;
      divisor_in   = divisor_ff;
      remainder_in = remainder_ff;
      quotient_in  = quotient_ff;
      overflow_in  = overflow_ff;
      if (start) begin
         busy_in      = 1'b1;
         count_in     = '0;
         dividend_in  = dividend;
         divisor_in   = divisor;
         remainder_in = '0;
         quotient_in  = '0;
         overflow_in  = 1'b0;
      end else if (busy_ff) begin
         dividend_in  = {dividend_ff[ACCUM_WIDTH-2:0], 1'b0};
         remainder_in = fits ? trial[RATE_WIDTH-1:0] : shifted[RATE_WIDTH-1:0];
         quotient_in  = {quotient_ff[STEP_WIDTH-2:0], fits};
         overflow_in  = overflow_ff | quotient_ff[STEP_WIDTH-1];
         count_in     = count_ff + 5'd1;
         if (count_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff     <= count_in;
      dividend_ff  <= dividend_in;
      divisor_ff   <= divisor_in;
      remainder_ff <= remainder_in;
      quotient_ff  <= quotient_in;
      overflow_ff  <= overflow_in;
   end

   assign result.done  = done_ff;
   assign result.steps = overflow_ff ? {STEP_WIDTH{1'b1}} : quotient_ff;

endmodule

[rtl/core/speed_step_momentum_ramp.sv]
// Speed step momentum ramp: takes one request at a time and returns one response.
// An emergency stop, a request already at goal or a zero rate goes straight to
// FINISH; any other request waits in DIVIDE for the 32 one-bit iterations of
// the serial divider. A new request is taken the cycle after the response is
// written. Reset (synchronous, active high) sets the speed to forward stop, clears
// the time accumulator and all three registers, and drops rsp_tvalid.
module speed_step_momentum_ramp
   import ssmr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // target_speed [7:0], elapsed_us [23:8], stop_reverse [24], zero [31:25]
   input  logic [31:0] req_tdata,
   // op [0]
   input  logic        req_tuser,

   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // speed_now [7:0], kick_start [8], at_goal [9], zero [15:10]
   output logic [15:0] rsp_tdata,

   // Register port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // ---------------------------------------------------------------------------
   // Configuration registers. A write lands on the access cycle; pready is tied
   // high so every transfer completes without wait states.
   // ---------------------------------------------------------------------------
   logic [RATE_WIDTH-1:0] accel_rate_ff;
   logic [RATE_WIDTH-1:0] decel_rate_ff;
   logic                  kick_enable_ff;
   logic                  csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_rate_ff  <= '0;
         decel_rate_ff  <= '0;
         kick_enable_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_ACCEL_RATE:  accel_rate_ff  <= csr_pwdata[RATE_WIDTH-1:0];
            REG_DECEL_RATE:  decel_rate_ff  <= csr_pwdata[RATE_WIDTH-1:0];
            REG_KICK_ENABLE: kick_enable_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_ACCEL_RATE:  csr_prdata = {8'd0, accel_rate_ff};
         REG_DECEL_RATE:  csr_prdata = {8'd0, decel_rate_ff};
         REG_KICK_ENABLE: csr_prdata = {31'd0, kick_enable_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Ramp state and the latched request.
   // ---------------------------------------------------------------------------
   ramp_state_type         state_ff, state_in;
   logic signed [7:0]      speed_ff, speed_in;
   logic [ACCUM_WIDTH-1:0] time_accum_ff, time_accum_in;

   logic                   op_ff;
   logic signed [7:0]      goal_ff;
   logic                   rev_ff;
   logic                   kick_ff;
   logic                   div_path_ff;
   logic [STEP_WIDTH-1:0]  steps_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [15:0]            rsp_data_ff;

   // Decode of the incoming request.
   logic                   req_op;
   logic signed [7:0]      req_goal_raw;
   logic signed [7:0]      req_goal;
   logic [ELAPSED_WIDTH-1:0] req_elapsed;
   logic                   req_rev;
   logic [RATE_WIDTH-1:0]  req_rate;
   logic                   req_div_path;
   logic                   req_kick;
   logic [ACCUM_WIDTH-1:0] accum_sum;

   assign req_op       = req_tuser;
   assign req_goal_raw = req_tdata[7:0];
   assign req_elapsed  = req_tdata[23:8];
   assign req_rev      = req_tdata[24];

   // A goal of zero means forward stop; the most negative code clips to -127.
   always_comb begin
      if (req_goal_raw == 8'sd0) begin
         req_goal = SPEED_FWD_STOP;
      end else if (req_goal_raw == SPEED_BAD_MIN) begin
         req_goal = SPEED_NEG_MAX;
      end else begin
         req_goal = req_goal_raw;
      end
   end

   // Moving away from zero uses the accel rate, toward zero the decel rate.
   always_comb begin
      if (speed_ff > req_goal) begin
         req_rate = (speed_ff < 8'sd0) ? accel_rate_ff : decel_rate_ff;
      end else begin
         req_rate = (speed_ff > 8'sd0) ? accel_rate_ff : decel_rate_ff;
      end
   end

   // Only an update that is off goal with a nonzero rate needs the divider.
   assign req_div_path = (req_op == OP_UPDATE) && (req_goal != speed_ff) &&
                         (req_rate != '0);
   assign accum_sum    = time_accum_ff + {{(ACCUM_WIDTH-ELAPSED_WIDTH){1'b0}}, req_elapsed};

   // Kick start: leaving a stop toward a goal in the same direction.
   assign req_kick = (req_op == OP_UPDATE) && (req_goal != speed_ff) && kick_enable_ff &&
                     ((speed_ff == SPEED_FWD_STOP && req_goal > 8'sd0) ||
                      (speed_ff == SPEED_REV_STOP && req_goal < 8'sd0));

   // ---------------------------------------------------------------------------
   // Serial divider: accumulated time over the selected rate.
   // ---------------------------------------------------------------------------
   logic           div_start;
   div_result_type div_result;

   ssmr_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (accum_sum),
      .divisor  (req_rate),
      .result   (div_result)
   );

   // ---------------------------------------------------------------------------
   // Step arithmetic, evaluated while the request finishes. Values are widened
   // to ten bits so a full 255-step move cannot wrap.
   // ---------------------------------------------------------------------------
   logic signed [9:0] cur_wide;
   logic signed [9:0] goal_wide;
   logic signed [9:0] up_wide;
   logic signed [9:0] down_wide;
   logic signed [7:0] jump_speed;
   logic signed [7:0] step_speed;
   logic signed [7:0] next_speed;
   logic [ACCUM_WIDTH-1:0] next_accum;
   logic              next_at_goal;

   assign cur_wide  = {{2{speed_ff[7]}}, speed_ff};
   assign goal_wide = {{2{goal_ff[7]}}, goal_ff};
   assign up_wide   = cur_wide + $signed({2'b00, steps_ff});
   assign down_wide = cur_wide - $signed({2'b00, steps_ff});

   // With a zero rate the speed jumps to the goal, but only to the opposite
   // stop when the direction would change.
   always_comb begin
      if (speed_ff < SPEED_REV_STOP && goal_ff > SPEED_REV_STOP) begin
         jump_speed = SPEED_FWD_STOP;
      end else if (speed_ff > SPEED_FWD_STOP && goal_ff < SPEED_FWD_STOP) begin
         jump_speed = SPEED_REV_STOP;
      end else begin
         jump_speed = goal_ff;
      end
   end

   // A step that reaches or crosses zero ends on the stop of the new direction; any other step never passes the goal.
   always_comb begin
      if (goal_ff > speed_ff) begin
         if (speed_ff < 8'sd0 && up_wide >= 10'sd0) begin
            step_speed = SPEED_FWD_STOP;
         end else if (up_wide >= goal_wide) begin
            step_speed = goal_ff;
         end else begin
            step_speed = up_wide[7:0];
         end
      end else begin
         if (speed_ff > 8'sd0 && down_wide <= 10'sd0) begin
            step_speed = SPEED_REV_STOP;
         end else if (down_wide <= goal_wide) begin
            step_speed = goal_ff;
         end else begin
            step_speed = down_wide[7:0];
         end
      end
   end

   always_comb begin
      next_speed = speed_ff;
      next_accum = time_accum_ff;
      if (op_ff == OP_ESTOP) begin
         next_speed = rev_ff ? SPEED_REV_STOP : SPEED_FWD_STOP;
      end else if (goal_ff == speed_ff) begin
         next_accum = '0;
      end else if (!div_path_ff) begin
         next_speed = jump_speed;
      end else if (steps_ff != '0) begin
         next_speed = step_speed;
         next_accum = '0;
      end
      next_at_goal = (op_ff == OP_ESTOP) || (next_speed == goal_ff);
   end

   // ---------------------------------------------------------------------------
   // Sequencer: IDLE takes a request, DIVIDE waits on the divider, FINISH
   // commits the new speed and writes the response once the output register
   // is free.
   // ---------------------------------------------------------------------------
   logic req_accept;
   logic finish_write;

   always_comb begin
      state_in      = state_ff;
      req_tready    = 1'b0;
      req_accept    = 1'b0;
      div_start     = 1'b0;
      finish_write  = 1'b0;
      speed_in      = speed_ff;
      time_accum_in = time_accum_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               req_accept = 1'b1;
               if (req_div_path) begin
                  div_start     = 1'b1;
                  time_accum_in = accum_sum;
                  state_in      = ST_DIVIDE;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_result.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               finish_write  = 1'b1;
               rsp_valid_in  = 1'b1;
               speed_in      = next_speed;
               time_accum_in = next_accum;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         speed_ff      <= SPEED_FWD_STOP;
         time_accum_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         speed_ff      <= speed_in;
         time_accum_ff <= time_accum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Latched request and response payload; no reset needed.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff       <= req_op;
         goal_ff     <= req_goal;
         rev_ff      <= req_rev;
         kick_ff     <= req_kick;
         div_path_ff <= req_div_path;
      end
      if (state_ff == ST_DIVIDE && div_result.done) begin
         steps_ff <= div_result.steps;
      end
      if (finish_write) begin
         rsp_data_ff <= {6'd0, next_at_goal, kick_ff, next_speed};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/core/ssmr_checker.sv]
// Port-level checks of the speed step momentum ramp, bound to the top level.
// Depends on ssmr_pkg and speed_step_momentum_ramp_defines.svh.
`include "speed_step_momentum_ramp_defines.svh"

module ssmr_checker
   import ssmr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // A stalled response keeps its payload.
   `SSMR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // One request at a time: the block is busy right after taking one.
   `SSMR_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)

   // The speed is never the unused zero code.
   `SSMR_ASSERT_HOLDS(a_speed_nonzero, clock, reset, rsp_tvalid, rsp_tdata[7:0] != 8'h00)

   // The speed never reaches the clipped most negative code.
   `SSMR_ASSERT_HOLDS(a_speed_in_range, clock, reset, rsp_tvalid, rsp_tdata[7:0] != SPEED_BAD_MIN)

endmodule

bind speed_step_momentum_ramp ssmr_checker u_ssmr_checker (.*);
